[hdl/vmx_pkg.sv]
`timescale 1ns / 1ps
package vmx_pkg;

   localparam int MemBytes   = 4096;
   localparam int StackDepth = 16;
   localparam int FontBytes  = 80;
   localparam logic [11:0] PcReset = 12'h200;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_EXEC  = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [11:0] address;
      logic [7:0]  write_byte;
      logic [15:0] keys_down;
      logic [7:0]  random_byte;
   } req_type_type;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic [11:0] program_counter;
      logic [15:0] executed_opcode;
      logic        draw_request;
      logic        sound_active;
      logic        waiting_key;
      logic        unknown_opcode;
   } rsp_type;

   function automatic logic [7:0] font_byte(input logic [6:0] idx);
      logic [7:0] f;
      case (idx)
         7'd0: f = 8'hF0; 7'd1: f = 8'h90; 7'd2: f = 8'h90; 7'd3: f = 8'h90;
         7'd4: f = 8'hF0; 7'd5: f = 8'h20; 7'd6: f = 8'h60; 7'd7: f = 8'h20;
         7'd8: f = 8'h20; 7'd9: f = 8'h70; 7'd10: f = 8'hF0; 7'd11: f = 8'h10;
         7'd12: f = 8'hF0; 7'd13: f = 8'h80; 7'd14: f = 8'hF0; 7'd15: f = 8'hF0;
         7'd16: f = 8'h10; 7'd17: f = 8'hF0; 7'd18: f = 8'h10; 7'd19: f = 8'hF0;
         7'd20: f = 8'h90; 7'd21: f = 8'h90; 7'd22: f = 8'hF0; 7'd23: f = 8'h10;
         7'd24: f = 8'h10; 7'd25: f = 8'hF0; 7'd26: f = 8'h80; 7'd27: f = 8'hF0;
         7'd28: f = 8'h10; 7'd29: f = 8'hF0; 7'd30: f = 8'hF0; 7'd31: f = 8'h80;
         7'd32: f = 8'hF0; 7'd33: f = 8'h90; 7'd34: f = 8'hF0; 7'd35: f = 8'hF0;
         7'd36: f = 8'h10; 7'd37: f = 8'h20; 7'd38: f = 8'h40; 7'd39: f = 8'h40;
         7'd40: f = 8'hF0; 7'd41: f = 8'h90; 7'd42: f = 8'hF0; 7'd43: f = 8'h90;
         7'd44: f = 8'hF0; 7'd45: f = 8'hF0; 7'd46: f = 8'h90; 7'd47: f = 8'hF0;
         7'd48: f = 8'h10; 7'd49: f = 8'hF0; 7'd50: f = 8'hF0; 7'd51: f = 8'h90;
         7'd52: f = 8'hF0; 7'd53: f = 8'h90; 7'd54: f = 8'h90; 7'd55: f = 8'hE0;
         7'd56: f = 8'h90; 7'd57: f = 8'hE0; 7'd58: f = 8'h90; 7'd59: f = 8'hE0;
         7'd60: f = 8'hF0; 7'd61: f = 8'h80; 7'd62: f = 8'h80; 7'd63: f = 8'h80;
         7'd64: f = 8'hF0; 7'd65: f = 8'hE0; 7'd66: f = 8'h90; 7'd67: f = 8'h90;
         7'd68: f = 8'h90; 7'd69: f = 8'hE0; 7'd70: f = 8'hF0; 7'd71: f = 8'h80;
         7'd72: f = 8'hF0; 7'd73: f = 8'h80; 7'd74: f = 8'hF0; 7'd75: f = 8'hF0;
         7'd76: f = 8'h80; 7'd77: f = 8'hF0; 7'd78: f = 8'h80; 7'd79: f = 8'h80;
         default: f = 8'h00;
      endcase
      return f;
   endfunction

endpackage

[hdl/vmx_memory.sv]
`timescale 1ns / 1ps
module vmx_memory
   import vmx_pkg::*;
#(
   parameter int MEM_BYTES = MemBytes,
   localparam int AW = $clog2(MEM_BYTES)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem [MEM_BYTES];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[hdl/vm_instruction_executor.sv]
`timescale 1ns / 1ps
// channel   ports                         direction
// request   req_valid req_stall req_data  in  (write, read or execute; any other type gets a bare response)
// response  rsp_valid rsp_stall rsp_data  out (one per request)
//
// after reset a clearing pass over all MEM_BYTES addresses writes the font and
// zeros; no request is taken during it. reset is synchronous, active high.
// a write is done in the accepting cycle, a read passes S_RD and S_RDW, an execute
// fetches in S_F0 to S_F2 and runs in S_EXEC, FX33, FX55 and FX65 then loop in
// S_BCD, S_ST or S_LDA to S_LDD; each request ends in S_FIN at the output register.
// a response waits in an output register while rsp_stall is high; the next
// request is taken once that register is empty.
module vm_instruction_executor
   import vmx_pkg::*;
#(
   parameter int MEM_BYTES   = MemBytes,
   parameter int STACK_DEPTH = StackDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_RDW   = 4'd3;
   localparam logic [3:0] S_F0    = 4'd4;
   localparam logic [3:0] S_F1    = 4'd5;
   localparam logic [3:0] S_F2    = 4'd6;
   localparam logic [3:0] S_EXEC  = 4'd7;
   localparam logic [3:0] S_BCD   = 4'd8;
   localparam logic [3:0] S_ST    = 4'd9;
   localparam logic [3:0] S_LDA   = 4'd10;
   localparam logic [3:0] S_LDW   = 4'd11;
   localparam logic [3:0] S_LDD   = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   req_type_type req_ff, req_in;
   logic [7:0]  v_ff [16];
   logic [7:0]  v_in [16];
   logic [15:0] i_ff, i_in;
   logic [11:0] pc_ff, pc_in;
   logic [11:0] stk_ff [STACK_DEPTH];
   logic        stk_we;
   logic [SW-1:0] sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in;
   logic [15:0] op_ff, op_in;
   logic [3:0]  k_ff, k_in;
   logic [3:0]  bcd_ff, bcd_in;
   logic [7:0]  rem_ff, rem_in;
   logic        draw_ff, draw_in, wait_ff, wait_in, unk_ff, unk_in;
   logic        ov_ff, ov_in;
   rsp_type     rsp_ff, rsp_in;

   logic          mwe;
   logic [AW-1:0] mwa, mra;
   logic [7:0]    mwd, mrd;

   vmx_memory #(.MEM_BYTES(MEM_BYTES)) u_mem (
      .clock(clock), .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd)
   );

   assign req_stall = (state_ff != S_IDLE) || ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_data  = rsp_ff;

   // decode fields
   logic [3:0]  x, y;
   logic [7:0]  nn, vx, vy;
   logic [11:0] nnn;
   logic [15:0] iadd;
   assign x   = op_ff[11:8];
   assign y   = op_ff[7:4];
   assign nn  = op_ff[7:0];
   assign nnn = op_ff[11:0];
   assign vx  = v_ff[x];
   assign vy  = v_ff[y];
   assign iadd = i_ff + {12'd0, k_ff};

   // shared 9-bit alu
   logic [8:0] alu;
   logic [11:0] next_pc;
   logic [SW-1:0] sp_dec, sp_inc;
   assign sp_dec = (sp_ff == '0) ? SW'(STACK_DEPTH - 1) : sp_ff - 1'b1;
   assign sp_inc = (sp_ff == SW'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;

   logic key_vx;
   assign key_vx = (vx[7:4] == 4'd0) && req_ff.keys_down[vx[3:0]];

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      req_in = req_ff;
      v_in = v_ff;
      i_in = i_ff;
      pc_in = pc_ff;
      sp_in = sp_ff;
      dt_in = dt_ff;
      st_in = st_ff;
      op_in = op_ff;
      k_in = k_ff;
      bcd_in = bcd_ff;
      rem_in = rem_ff;
      draw_in = draw_ff;
      wait_in = wait_ff;
      unk_in = unk_ff;
      ov_in = ov_ff && rsp_stall;
      rsp_in = rsp_ff;
      stk_we = 1'b0;
      mwe = 1'b0;
      mwa = clr_ff[AW-1:0];
      mwd = 8'd0;
      mra = req_ff.address[AW-1:0];
      alu = 9'd0;
      next_pc = pc_ff + 12'd2;
      case (state_ff)
         // clearing pass with font
         S_CLEAR: begin
            mwe = 1'b1;
            mwd = (clr_ff < (AW+1)'(FontBytes)) ? font_byte(clr_ff[6:0]) : 8'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && !ov_ff) begin
               req_in = req_data;
               op_in = 16'd0;
               draw_in = 1'b0;
               wait_in = 1'b0;
               unk_in = 1'b0;
               rem_in = 8'd0;
               case (req_data.req_type)
                  REQ_WRITE: begin
                     mwe = 1'b1;
                     mwa = req_data.address[AW-1:0];
                     mwd = req_data.write_byte;
                     state_in = S_FIN;
                  end
                  REQ_READ: state_in = S_RD;
                  REQ_EXEC: state_in = S_F0;
                  default:  state_in = S_FIN;
               endcase
            end
         end
         S_RD: state_in = S_RDW;
         S_RDW: begin
            rem_in = mrd;
            state_in = S_FIN;
         end
         // fetch two opcode bytes
         S_F0: begin
            mra = pc_ff[AW-1:0];
            state_in = S_F1;
         end
         S_F1: begin
            mra = AW'(pc_ff + 12'd1);
            op_in[15:8] = mrd;
            state_in = S_F2;
         end
         S_F2: begin
            op_in[7:0] = mrd;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FIN;
            case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == 16'h00E0) begin
                     draw_in = 1'b1;
                  end else if (op_ff == 16'h00EE) begin
                     sp_in = sp_dec;
                     next_pc = stk_ff[sp_dec] + 12'd2;
                  end else begin
                     unk_in = 1'b1;
                  end
               end
               4'h1: next_pc = nnn;
               4'h2: begin
                  stk_we = 1'b1;
                  sp_in = sp_inc;
                  next_pc = nnn;
               end
               4'h3: if (vx == nn) next_pc = pc_ff + 12'd4;
               4'h4: if (vx != nn) next_pc = pc_ff + 12'd4;
               4'h5: if (vx == vy) next_pc = pc_ff + 12'd4;
               4'h6: v_in[x] = nn;
               4'h7: begin
                  alu = {1'b0, vx} + {1'b0, nn};
                  v_in[x] = alu[7:0];
               end
               4'h8: begin
                  case (op_ff[3:0])
                     4'h0: v_in[x] = vy;
                     4'h1: v_in[x] = vx | vy;
                     4'h2: v_in[x] = vx & vy;
                     4'h3: v_in[x] = vx ^ vy;
                     4'h4: begin
                        alu = {1'b0, vx} + {1'b0, vy};
                        v_in[x] = alu[7:0];
                        v_in[15] = {7'd0, alu[8]};
                     end
                     4'h5: begin
                        alu = {1'b0, vx} - {1'b0, vy};
                        v_in[x] = alu[7:0];
                        v_in[15] = {7'd0, ~alu[8]};
                     end
                     4'h6: begin
                        v_in[x] = {1'b0, vx[7:1]};
                        v_in[15] = {7'd0, vx[0]};
                     end
                     4'h7: begin
                        alu = {1'b0, vy} - {1'b0, vx};
                        v_in[x] = alu[7:0];
                        v_in[15] = {7'd0, ~alu[8]};
                     end
                     4'hE: begin
                        v_in[x] = {vx[6:0], 1'b0};
                        v_in[15] = {7'd0, vx[7]};
                     end
                     default: unk_in = 1'b1;
                  endcase
               end
               4'h9: if (vx != vy) next_pc = pc_ff + 12'd4;
               4'hA: i_in = {4'd0, nnn};
               4'hB: next_pc = {4'd0, v_ff[0]} + nnn;
               4'hC: v_in[x] = req_ff.random_byte & nn;
               4'hD: draw_in = 1'b1;
               4'hE: begin
                  if (nn == 8'h9E) begin
                     if (key_vx) next_pc = pc_ff + 12'd4;
                  end else if (nn == 8'hA1) begin
                     if (!key_vx) next_pc = pc_ff + 12'd4;
                  end else begin
                     unk_in = 1'b1;
                  end
               end
               default: begin
                  case (nn)
                     8'h07: v_in[x] = dt_ff;
                     8'h0A: begin
                        if (req_ff.keys_down == 16'd0) begin
                           wait_in = 1'b1;
                           next_pc = pc_ff;
                        end else begin
                           for (int b = 0; b < 16; b++) begin
                              if (req_ff.keys_down[b]) v_in[x] = 8'(b);
                           end
                        end
                     end
                     8'h15: dt_in = vx;
                     8'h18: st_in = vx;
                     8'h1E: i_in = i_ff + {8'd0, vx};
                     8'h29: i_in = {10'd0, vx[3:0], 2'b00} + {12'd0, vx[3:0]};
                     8'h33: begin
                        rem_in = vx;
                        bcd_in = 4'd0;
                        k_in = 4'd0;
                        state_in = S_BCD;
                     end
                     8'h55: begin
                        k_in = 4'd0;
                        state_in = S_ST;
                     end
                     8'h65: begin
                        k_in = 4'd0;
                        state_in = S_LDA;
                     end
                     default: unk_in = 1'b1;
                  endcase
               end
            endcase
            pc_in = next_pc;
            // timers count down after every executed instruction
            dt_in = (dt_in != 8'd0) ? dt_in - 8'd1 : 8'd0;
            st_in = (st_in != 8'd0) ? st_in - 8'd1 : 8'd0;
         end
         // bcd: repeated subtraction of 100 then 10, one digit per pass
         S_BCD: begin
            if (k_ff == 4'd2) begin
               mwe = 1'b1;
               mwa = AW'(i_ff + 16'd2);
               mwd = rem_ff;
               rem_in = 8'd0;
               state_in = S_FIN;
            end else begin
               alu = {1'b0, rem_ff} - ((k_ff == 4'd0) ? 9'd100 : 9'd10);
               if (!alu[8]) begin
                  rem_in = alu[7:0];
                  bcd_in = bcd_ff + 4'd1;
               end else begin
                  mwe = 1'b1;
                  mwa = AW'(iadd);
                  mwd = {4'd0, bcd_ff};
                  bcd_in = 4'd0;
                  k_in = k_ff + 4'd1;
               end
            end
         end
         S_ST: begin
            mwe = 1'b1;
            mwa = AW'(iadd);
            mwd = v_ff[k_ff];
            k_in = k_ff + 4'd1;
            if (k_ff == x) begin
               i_in = iadd + 16'd1;
               state_in = S_FIN;
            end
         end
         S_LDA: begin
            mra = AW'(iadd);
            state_in = S_LDW;
         end
         S_LDW: begin
            mra = AW'(iadd);
            state_in = S_LDD;
         end
         S_LDD: begin
            mra = AW'(iadd);
            v_in[k_ff] = mrd;
            k_in = k_ff + 4'd1;
            if (k_ff == x) begin
               i_in = iadd + 16'd1;
               state_in = S_FIN;
            end else begin
               state_in = S_LDA;
            end
         end
         // load the output register
         S_FIN: begin
            rsp_in.read_byte = (req_ff.req_type == REQ_READ) ? rem_ff : 8'd0;
            rsp_in.program_counter = pc_ff;
            rsp_in.executed_opcode = op_ff;
            rsp_in.draw_request = draw_ff;
            rsp_in.sound_active = (st_ff != 8'd0);
            rsp_in.waiting_key = wait_ff;
            rsp_in.unknown_opcode = unk_ff;
            ov_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         ov_ff <= 1'b0;
         pc_ff <= PcReset;
         i_ff <= 16'd0;
         sp_ff <= '0;
         dt_ff <= 8'd0;
         st_ff <= 8'd0;
         for (int r = 0; r < 16; r++) v_ff[r] <= 8'd0;
         for (int s = 0; s < STACK_DEPTH; s++) stk_ff[s] <= 12'd0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         ov_ff <= ov_in;
         pc_ff <= pc_in;
         i_ff <= i_in;
         sp_ff <= sp_in;
         dt_ff <= dt_in;
         st_ff <= st_in;
         v_ff <= v_in;
         if (stk_we) stk_ff[sp_ff] <= pc_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      op_ff <= op_in;
      k_ff <= k_in;
      bcd_ff <= bcd_in;
      rem_ff <= rem_in;
      draw_ff <= draw_in;
      wait_ff <= wait_in;
      unk_ff <= unk_in;
      rsp_ff <= rsp_in;
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
   import vmx_pkg::*;

   localparam int ITEM_COUNT = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] REQ_NOP = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   vm_instruction_executor i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // machine state mirrored by the predictor
   logic [7:0]  mem_image [MemBytes];
   logic [7:0]  v_regs [16];
   logic [15:0] idx_reg;
   logic [11:0] pc_reg;
   logic [11:0] ret_stack [StackDepth];
   int          ret_ptr;
   logic [7:0]  delay_tmr;
   logic [7:0]  sound_tmr;

   rsp_type     expected_rsp [$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          quiet_mode = 1'b0;
   bit          hold_rsp = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic reset_machine();
      for (int a = 0; a < MemBytes; a++)
         mem_image[a] = (a < FontBytes) ? font_byte(a[6:0]) : 8'h00;
      for (int r = 0; r < 16; r++) v_regs[r] = 8'h00;
      for (int s = 0; s < StackDepth; s++) ret_stack[s] = 12'h000;
      idx_reg = '0;
      pc_reg = PcReset;
      ret_ptr = 0;
      delay_tmr = '0;
      sound_tmr = '0;
   endtask

   function automatic bit key_is_down(logic [15:0] keys, logic [7:0] v);
      return (v > 8'd15) ? 1'b0 : keys[v[3:0]];
   endfunction

   // execute one request against the mirrored state
   function automatic rsp_type run_request(req_type_type rq);
      rsp_type     o;
      logic [15:0] op;
      logic [11:0] nxt;
      logic [3:0]  x, y;
      logic [7:0]  nn, vx, vy;
      logic [8:0]  sum;
      o = '0;
      case (rq.req_type)
         REQ_WRITE: mem_image[rq.address] = rq.write_byte;
         REQ_READ:  o.read_byte = mem_image[rq.address];
         REQ_EXEC: begin
            op = {mem_image[pc_reg], mem_image[pc_reg + 12'd1]};
            x = op[11:8];
            y = op[7:4];
            nn = op[7:0];
            vx = v_regs[x];
            vy = v_regs[y];
            nxt = pc_reg + 12'd2;
            case (op[15:12])
               4'h0: begin
                  if (op == 16'h00E0) o.draw_request = 1'b1;
                  else if (op == 16'h00EE) begin
                     ret_ptr = (ret_ptr + StackDepth - 1) % StackDepth;
                     nxt = ret_stack[ret_ptr] + 12'd2;
                  end else o.unknown_opcode = 1'b1;
               end
               4'h1: nxt = op[11:0];
               4'h2: begin
                  ret_stack[ret_ptr] = pc_reg;
                  ret_ptr = (ret_ptr + 1) % StackDepth;
                  nxt = op[11:0];
               end
               4'h3: if (vx == nn) nxt += 12'd2;
               4'h4: if (vx != nn) nxt += 12'd2;
               4'h5: if (vx == vy) nxt += 12'd2;
               4'h6: v_regs[x] = nn;
               4'h7: v_regs[x] = vx + nn;
               4'h8: case (op[3:0])
                  4'h0: v_regs[x] = vy;
                  4'h1: v_regs[x] = vx | vy;
                  4'h2: v_regs[x] = vx & vy;
                  4'h3: v_regs[x] = vx ^ vy;
                  4'h4: begin
                     sum = vx + vy;
                     v_regs[x] = sum[7:0];
                     v_regs[15] = {7'd0, sum[8]};
                  end
                  4'h5: begin
                     v_regs[x] = vx - vy;
                     v_regs[15] = {7'd0, vx >= vy};
                  end
                  4'h6: begin
                     v_regs[x] = vx >> 1;
                     v_regs[15] = {7'd0, vx[0]};
                  end
                  4'h7: begin
                     v_regs[x] = vy - vx;
                     v_regs[15] = {7'd0, vy >= vx};
                  end
                  4'hE: begin
                     v_regs[x] = vx << 1;
                     v_regs[15] = {7'd0, vx[7]};
                  end
                  default: o.unknown_opcode = 1'b1;
               endcase
               4'h9: if (vx != vy) nxt += 12'd2;
               4'hA: idx_reg = {4'h0, op[11:0]};
               4'hB: nxt = {4'h0, v_regs[0]} + op[11:0];
               4'hC: v_regs[x] = rq.random_byte & nn;
               4'hD: o.draw_request = 1'b1;
               4'hE: begin
                  if (nn == 8'h9E) begin
                     if (key_is_down(rq.keys_down, vx)) nxt += 12'd2;
                  end else if (nn == 8'hA1) begin
                     if (!key_is_down(rq.keys_down, vx)) nxt += 12'd2;
                  end else o.unknown_opcode = 1'b1;
               end
               default: case (nn)
                  8'h07: v_regs[x] = delay_tmr;
                  8'h0A: begin
                     if (rq.keys_down == '0) begin
                        o.waiting_key = 1'b1;
                        nxt = pc_reg;
                     end else
                        for (int k = 0; k < 16; k++)
                           if (rq.keys_down[k]) v_regs[x] = k[7:0];
                  end
                  8'h15: delay_tmr = vx;
                  8'h18: sound_tmr = vx;
                  8'h1E: idx_reg = idx_reg + vx;
                  8'h29: idx_reg = vx[3:0] * 16'd5;
                  8'h33: begin
                     mem_image[idx_reg[11:0]] = vx / 8'd100;
                     mem_image[idx_reg[11:0] + 12'd1] = (vx / 8'd10) % 8'd10;
                     mem_image[idx_reg[11:0] + 12'd2] = vx % 8'd10;
                  end
                  8'h55: begin
                     for (int k = 0; k <= x; k++)
                        mem_image[idx_reg[11:0] + k[11:0]] = v_regs[k];
                     idx_reg = idx_reg + x + 16'd1;
                  end
                  8'h65: begin
                     for (int k = 0; k <= x; k++)
                        v_regs[k] = mem_image[idx_reg[11:0] + k[11:0]];
                     idx_reg = idx_reg + x + 16'd1;
                  end
                  default: o.unknown_opcode = 1'b1;
               endcase
            endcase
            pc_reg = nxt;
            o.executed_opcode = op;
            if (delay_tmr != 0) delay_tmr--;
            if (sound_tmr != 0) sound_tmr--;
         end
         default: ;
      endcase
      o.program_counter = pc_reg;
      o.sound_active = (sound_tmr != 0);
      return o;
   endfunction

   // one request transfer; predicts when accepted, valid stays up until
   // the next request or an explicit drop
   task automatic send_request(input req_type_type rq);
      while (!quiet_mode && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(run_request(rq));
   endtask

   task automatic drop_request();
      req_valid <= 1'b0;
   endtask

   task automatic write_byte_at(input logic [11:0] a, input logic [7:0] b);
      req_type_type rq;
      rq = '0;
      rq.req_type = REQ_WRITE;
      rq.address = a;
      rq.write_byte = b;
      send_request(rq);
   endtask

   task automatic exec_op(input logic [15:0] keys, input logic [7:0] rnd);
      req_type_type rq;
      rq = '0;
      rq.req_type = REQ_EXEC;
      rq.keys_down = keys;
      rq.random_byte = rnd;
      rq.address = 12'($urandom);
      send_request(rq);
   endtask

   // place opcode at the current pc and run it
   task automatic load_and_exec(input logic [15:0] op, input logic [15:0] keys,
                                input logic [7:0] rnd);
      write_byte_at(pc_reg, op[15:8]);
      write_byte_at(pc_reg + 12'd1, op[7:0]);
      exec_op(keys, rnd);
   endtask

   function automatic logic [15:0] random_opcode();
      logic [15:0] op;
      logic [7:0]  f_codes [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29,
                                   8'h33, 8'h55, 8'h65};
      op = 16'($urandom);
      case ($urandom_range(15))
         0: op = ($urandom_range(1)) ? 16'h00E0 : 16'h00EE;
         8: op[3:0] = ($urandom_range(7) == 0) ? op[3:0] : 4'($urandom_range(7));
         14: op[7:0] = ($urandom_range(4) == 0) ? op[7:0] :
                       ($urandom_range(1) ? 8'h9E : 8'hA1);
         15: op[7:0] = ($urandom_range(9) == 0) ? op[7:0] : f_codes[$urandom_range(8)];
         default: ;
      endcase
      return op;
   endfunction

   // compare transfers against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (rsp_valid && !rsp_stall && !reset) begin
         if (expected_rsp.size() == 0)
            report_mismatch("unexpected response", int'(rsp_data.executed_opcode), 0);
         else begin
            want = expected_rsp.pop_front();
            if (rsp_data.read_byte !== want.read_byte)
               report_mismatch("read_byte", rsp_data.read_byte, want.read_byte);
            if (rsp_data.program_counter !== want.program_counter)
               report_mismatch("program_counter", rsp_data.program_counter,
                               want.program_counter);
            if (rsp_data.executed_opcode !== want.executed_opcode)
               report_mismatch("executed_opcode", rsp_data.executed_opcode,
                               want.executed_opcode);
            if (rsp_data.draw_request !== want.draw_request)
               report_mismatch("draw_request", rsp_data.draw_request, want.draw_request);
            if (rsp_data.sound_active !== want.sound_active)
               report_mismatch("sound_active", rsp_data.sound_active, want.sound_active);
            if (rsp_data.waiting_key !== want.waiting_key)
               report_mismatch("waiting_key", rsp_data.waiting_key, want.waiting_key);
            if (rsp_data.unknown_opcode !== want.unknown_opcode)
               report_mismatch("unknown_opcode", rsp_data.unknown_opcode,
                               want.unknown_opcode);
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout");
         $display("tb failed");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (quiet_mode) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 31);
   end

   typedef struct {
      logic [15:0] op;
      logic [15:0] keys;
      logic [7:0]  rnd;
   } exec_row_type;

   // directed programs, each written at the current pc then executed
   exec_row_type directed_rows [] = '{
      '{16'h00E0, 16'h0000, 8'h00},  // clear screen raises draw
      '{16'h60FF, 16'h0000, 8'h00},  // v0 = ff
      '{16'h61FF, 16'h0000, 8'h00},
      '{16'h8014, 16'h0000, 8'h00},  // add with carry
      '{16'h8015, 16'h0000, 8'h00},  // sub with borrow, vx < vy
      '{16'h8017, 16'h0000, 8'h00},
      '{16'h810E, 16'h0000, 8'h00},  // shift left flag
      '{16'h8F16, 16'h0000, 8'h00},  // flag wins when x is f
      '{16'hC2AA, 16'h0000, 8'hFF},  // random masked
      '{16'h3255, 16'h0000, 8'h00},
      '{16'h4200, 16'h0000, 8'h00},
      '{16'h5010, 16'h0000, 8'h00},
      '{16'h9125, 16'h0000, 8'h00},
      '{16'h6305, 16'h0000, 8'h00},
      '{16'hE39E, 16'h0020, 8'h00},  // key pressed skip
      '{16'hE1A1, 16'hFFFF, 8'h00},  // key above 15 not pressed
      '{16'hF40A, 16'h0000, 8'h00},  // wait for key holds pc
      '{16'hF40A, 16'h8001, 8'h00},  // highest key taken
      '{16'hF318, 16'h0000, 8'h00},
      '{16'hA300, 16'h0000, 8'h00},
      '{16'hF033, 16'h0000, 8'h00},
      '{16'hFF55, 16'h0000, 8'h00},
      '{16'hFF65, 16'h0000, 8'h00},
      '{16'h0123, 16'h0000, 8'h00},  // unknown 0nnn
      '{16'h2400, 16'h0000, 8'h00}   // call then return below
   };

   initial begin
      req_type_type rq;
      int           items;
      reset_machine();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fixed checks after reset: font byte, pc and a nop request
      rq = '0;
      rq.req_type = REQ_READ;
      rq.address = 12'd5;
      send_request(rq);
      if (expected_rsp[$].read_byte != 8'h20) report_mismatch("font", 0, 8'h20);
      rq.req_type = REQ_NOP;
      send_request(rq);
      if (expected_rsp[$].program_counter != PcReset)
         report_mismatch("reset pc", expected_rsp[$].program_counter, PcReset);

      foreach (directed_rows[i])
         load_and_exec(directed_rows[i].op, directed_rows[i].keys, directed_rows[i].rnd);
      load_and_exec(16'h00EE, 16'h0000, 8'h00);
      load_and_exec(16'hBFFF, 16'h0000, 8'h00);  // jump wraps pc
      rq = '0;
      rq.req_type = REQ_READ;
      rq.address = 12'hFFF;
      send_request(rq);
      drop_request();

      // sender pause until drained
      wait (expected_rsp.size() == 0);

      // receiver holds off while the sender keeps offering
      fork
         begin
            hold_rsp = 1'b1;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            repeat (6) load_and_exec(random_opcode(), 16'($urandom), 8'($urandom));
            drop_request();
         end
      join

      // random programs, mostly writes of an opcode then its execution
      items = 0;
      while (items < ITEM_COUNT) begin
         quiet_mode = (items >= 150 && items < 210);
         case ($urandom_range(9))
            0: begin
               rq = '0;
               rq.address = 12'($urandom);
               rq.write_byte = 8'($urandom);
               rq.keys_down = 16'($urandom);
               rq.random_byte = 8'($urandom);
               rq.req_type = $urandom_range(1) ? REQ_READ : REQ_WRITE;
               if ($urandom_range(1)) rq.req_type = 2'($urandom_range(3));
               send_request(rq);
               items++;
            end
            1: begin
               exec_op(16'($urandom), 8'($urandom));
               items++;
            end
            default: begin
               load_and_exec(random_opcode(),
                             $urandom_range(1) ? 16'h0000 : 16'($urandom), 8'($urandom));
               items += 3;
            end
         endcase
      end
      drop_request();

      wait (expected_rsp.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end
endmodule

[files.f]
hdl/vmx_pkg.sv
hdl/vmx_memory.sv
hdl/vm_instruction_executor.sv
tb/sv/tb.sv
